// File: hw/rtl/brf_pkg.sv
// brf_pkg: shared constants, codes and structs of the byte ring FIFO.
// Used by brf_ptr, byte_ring_fifo and brf_checker. No dependencies.
package brf_pkg;

  localparam int DEPTH     = 256;
  localparam int AW        = $clog2(DEPTH);
  localparam int DW        = 8;
  localparam int SW        = 9;            // ring size register width
  localparam int MAX_BURST = 64;
  localparam int BW        = 7;            // burst length / counter width
  localparam logic [SW-1:0] SIZE_MIN   = SW'(2);
  localparam logic [SW-1:0] SIZE_CAP   = SW'((DEPTH < 256) ? DEPTH : 256);
  localparam logic [BW-1:0] BURST_SAT  = BW'(MAX_BURST);

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_BURST = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // pointer update request
  typedef struct packed {
    logic          flush;
    logic [SW-1:0] size;
    logic          push;
    logic          pop;
    logic          set_ovf;
    logic          clr_ovf;
  } ptr_cmd_t;

  // pointer state and derived status
  typedef struct packed {
    logic [AW-1:0] head;
    logic [AW-1:0] tail;
    logic [SW-1:0] fill;
    logic [SW-1:0] free;
    logic          full;
    logic          empty;
    logic          ovf;
  } ptr_stat_t;

endpackage

// File: hw/rtl/brf_ram.sv
// brf_ram: single-write, single-read synchronous RAM, registered read data.
// Generic; no package dependency.
module brf_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/brf_ptr.sv
// brf_ptr: head/tail pointers, ring size, sticky overflow and fill status.
// Depends on brf_pkg.
module brf_ptr import brf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ptr_cmd_t  cmd,
  output ptr_stat_t stat
);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic          ovf_r, ovf_nxt;
  logic [SW-1:0] head_p1, tail_p1;
  logic [AW-1:0] head_inc, tail_inc;
  logic [SW-1:0] fill;

  always_comb begin
    head_p1  = {1'b0, head_r} + SW'(1);
    tail_p1  = {1'b0, tail_r} + SW'(1);
    head_inc = (head_p1 == size_r) ? '0 : head_p1[AW-1:0];
    tail_inc = (tail_p1 == size_r) ? '0 : tail_p1[AW-1:0];
    if (tail_r >= head_r) begin
      fill = {1'b0, tail_r} - {1'b0, head_r};
    end else begin
      fill = {1'b0, tail_r} + size_r - {1'b0, head_r};
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    size_nxt = size_r;
    ovf_nxt  = ovf_r;
    if (cmd.flush) begin
      head_nxt = '0;
      tail_nxt = '0;
      ovf_nxt  = 1'b0;
      if (cmd.size < SIZE_MIN) begin
        size_nxt = SIZE_MIN;
      end else if (cmd.size > SIZE_CAP) begin
        size_nxt = SIZE_CAP;
      end else begin
        size_nxt = cmd.size;
      end
    end else begin
      if (cmd.push)    tail_nxt = tail_inc;
      if (cmd.pop)     head_nxt = head_inc;
      if (cmd.set_ovf) ovf_nxt  = 1'b1;
      if (cmd.clr_ovf) ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      size_r <= SIZE_CAP;
      ovf_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      size_r <= size_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_comb begin
    stat.head  = head_r;
    stat.tail  = tail_r;
    stat.fill  = fill;
    stat.free  = size_r - SW'(1) - fill;
    stat.full  = (tail_inc == head_r);
    stat.empty = (head_r == tail_r);
    stat.ovf   = ovf_r;
  end

endmodule

// File: hw/rtl/byte_ring_fifo.sv
// byte_ring_fifo: top level of the byte ring FIFO.
// Depends on brf_pkg, brf_ram and brf_ptr.
//
// A byte FIFO in a 256-entry RAM used as a ring of cfg_wdata slots (2..256,
// clamped), one slot kept empty. An item transfers at a clock edge with start
// high and busy low. Push, pop and peek never raise busy, so one of them may
// transfer every cycle while busy is low; a burst of n bytes holds busy high
// until its last byte is popped, one byte popped per cycle, set by the single
// read port of the RAM. Each result shows on the out_ ports in the
// cycle after the edge that produced it, flagged by out_strobe; the
// receiver cannot stall it and must take it then. Fill count, free space,
// full, empty and overflow on a result reflect the state after that result.
// A write to cfg_wdata (cfg_we high) flushes the ring and clears overflow;
// only write it while no burst is in flight. No clearing pass after reset.
module byte_ring_fifo import brf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  // configuration
  input  logic          cfg_we,
  input  logic [SW-1:0] cfg_wdata,
  // command
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_action,
  input  logic [DW-1:0] in_data_in,
  input  logic [BW-1:0] in_burst_len,
  // result
  output logic          out_strobe,
  output logic [1:0]    out_status,
  output logic [DW-1:0] out_data_out,
  output logic          out_data_valid,
  output logic          out_last,
  output logic [7:0]    out_fill_count,
  output logic [7:0]    out_free_space,
  output logic          out_is_full,
  output logic          out_is_empty,
  output logic          out_overflow_flag
);

  ptr_cmd_t      cmd;
  ptr_stat_t     stat;
  logic [DW-1:0] rd_data;
  logic          accept;
  act_t          act;
  logic [BW-1:0] blen_sat;
  logic [BW-1:0] burst_n;

  // remaining bytes of a burst after the one in flight
  logic [BW-1:0] burst_left_r, burst_left_nxt;
  logic          strobe_r, strobe_nxt;
  status_t       status_r, status_nxt;
  logic          valid_r, valid_nxt;
  logic          last_r, last_nxt;

  assign busy   = (burst_left_r != '0);
  assign accept = start && !busy;
  assign act    = act_t'(in_action);

  // burst size: clamp request, then limit to what is stored
  always_comb begin
    blen_sat = (in_burst_len > BURST_SAT) ? BURST_SAT : in_burst_len;
    if ({{(SW-BW){1'b0}}, blen_sat} < stat.fill) begin
      burst_n = blen_sat;
    end else begin
      burst_n = stat.fill[BW-1:0];
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.flush      = cfg_we;
    cmd.size       = cfg_wdata;
    burst_left_nxt = burst_left_r;
    strobe_nxt     = 1'b0;
    status_nxt     = ST_OK;
    valid_nxt      = 1'b0;
    last_nxt       = 1'b1;
    if (busy) begin
      // burst continuation: one byte per cycle
      cmd.pop        = 1'b1;
      strobe_nxt     = 1'b1;
      valid_nxt      = 1'b1;
      last_nxt       = (burst_left_r == BW'(1));
      burst_left_nxt = burst_left_r - BW'(1);
    end else if (accept) begin
      strobe_nxt = 1'b1;
      unique case (act)
        ACT_PUSH: begin
          if (stat.full) begin
            cmd.set_ovf = 1'b1;
            status_nxt  = ST_FULL;
          end else begin
            cmd.push = 1'b1;
          end
        end
        ACT_POP: begin
          if (stat.empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.pop     = 1'b1;
            cmd.clr_ovf = 1'b1;
            valid_nxt   = 1'b1;
          end
        end
        ACT_PEEK: begin
          if (stat.empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            valid_nxt = 1'b1;
          end
        end
        ACT_BURST: begin
          cmd.clr_ovf = 1'b1;
          if (burst_n == '0) begin
            status_nxt = stat.empty ? ST_EMPTY : ST_OK;
          end else begin
            cmd.pop        = 1'b1;
            valid_nxt      = 1'b1;
            last_nxt       = (burst_n == BW'(1));
            burst_left_nxt = burst_n - BW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_left_r <= '0;
      strobe_r     <= 1'b0;
      status_r     <= ST_OK;
      valid_r      <= 1'b0;
      last_r       <= 1'b0;
    end else begin
      burst_left_r <= burst_left_nxt;
      strobe_r     <= strobe_nxt;
      status_r     <= status_nxt;
      valid_r      <= valid_nxt;
      last_r       <= last_nxt;
    end
  end

  brf_ptr u_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // RAM reads the head every cycle; the byte lands with the result cycle.
  // A push writes at an edge before any later read of that slot, so no forwarding needed.
  brf_ram #(
    .AW (AW),
    .DW (DW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (stat.tail),
    .wdata (in_data_in),
    .raddr (stat.head),
    .rdata (rd_data)
  );

  // status fields come straight from the pointers: they already hold the
  // state after the result being shown
  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_data_valid    = valid_r;
  assign out_data_out      = valid_r ? rd_data : '0;
  assign out_last          = last_r;
  assign out_fill_count    = stat.fill[7:0];
  assign out_free_space    = stat.free[7:0];
  assign out_is_full       = stat.full;
  assign out_is_empty      = stat.empty;
  assign out_overflow_flag = stat.ovf;

endmodule

// File: hw/rtl/brf_checker.sv
// brf_checker: port-level assertions for byte_ring_fifo, bound to the top.
// Depends on brf_pkg.
module brf_checker import brf_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          busy,
  input logic          out_strobe,
  input logic [1:0]    out_status,
  input logic          out_data_valid,
  input logic          out_last,
  input logic          out_is_full,
  input logic          out_is_empty,
  input logic          out_overflow_flag
);

  // burst results follow one another without gaps
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("burst result stream broke");

  // a busy cycle always produces a result next cycle
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("no result while busy");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_is_full && out_is_empty))
    else $error("full and empty together");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data_valid |-> out_status == ST_OK)
    else $error("data with failing status");

  a_full_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_FULL |-> out_overflow_flag && out_is_full)
    else $error("full push without overflow flag");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_data_valid    (out_data_valid),
  .out_last          (out_last),
  .out_is_full       (out_is_full),
  .out_is_empty      (out_is_empty),
  .out_overflow_flag (out_overflow_flag)
);
